// ----- hw/rtl/trm_pkg.sv -----
// Shared types, codes and helpers for the tiny register machine execute core.
// Used by trm_alu, the top level and the port checker; depends on nothing.

package trm_pkg;

  localparam int DATA_BITS_DEF  = 32;
  localparam int INDEX_BITS_DEF = 16;
  localparam int REG_COUNT      = 4;

  // Stream payload layout, lowest field first.
  localparam int OP_BITS    = 8;
  localparam int SEL_BITS   = 16;
  localparam int IMM_BITS   = 32;
  localparam int S_DATA_BITS = 56;

  localparam int STATUS_BITS = 3;
  localparam int REG_OUT_BITS = 32;
  localparam int NEXT_OUT_BITS = 16;
  localparam int M_USED_BITS = STATUS_BITS + 4 * REG_OUT_BITS + 2 + NEXT_OUT_BITS;
  localparam int M_DATA_BITS = ((M_USED_BITS + 7) / 8) * 8;

  // Opcodes.
  localparam logic [OP_BITS-1:0] OP_HALT = 8'd0;
  localparam logic [OP_BITS-1:0] OP_LOAD = 8'd1;
  localparam logic [OP_BITS-1:0] OP_ADD  = 8'd2;
  localparam logic [OP_BITS-1:0] OP_SUB  = 8'd3;
  localparam logic [OP_BITS-1:0] OP_MULT = 8'd4;
  localparam logic [OP_BITS-1:0] OP_DIV  = 8'd5;
  localparam logic [OP_BITS-1:0] OP_CMP  = 8'd6;
  localparam logic [OP_BITS-1:0] OP_JUMP = 8'd7;

  // Result status codes.
  localparam logic [STATUS_BITS-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_HALT    = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_BADREG  = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_DIVZERO = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_BADJUMP = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_IGNORED = 3'd5;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_CMP
  } alu_op_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_SIMPLE,
    A_MUL,
    A_NEGA,
    A_NEGB,
    A_DIV,
    A_FIX
  } alu_state_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_DECODE,
    C_READB,
    C_WAIT,
    C_RESULT
  } core_state_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic eq;
    logic lt;
  } alu_rsp_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] idx;
  } sel_pick_t;

  // A one-hot nibble of 8, 4, 2 or 1 picks register one, two, three or four.
  function automatic sel_pick_t sel_pick(input logic [3:0] nib);
    sel_pick_t p;
    p.ok  = 1'b1;
    p.idx = 2'd0;
    case (nib)
      4'b1000: p.idx = 2'd0;
      4'b0100: p.idx = 2'd1;
      4'b0010: p.idx = 2'd2;
      4'b0001: p.idx = 2'd3;
      default: p.ok = 1'b0;
    endcase
    return p;
  endfunction

endpackage

// ----- hw/rtl/trm_alu.sv -----
// Iterative arithmetic unit of the tiny register machine: one shared adder
// under a small sequencer does add, sub, compare, shift-add multiply and
// restoring divide. Depends on trm_pkg.

module trm_alu #(
  parameter int DATA_BITS = trm_pkg::DATA_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  trm_pkg::alu_req_t    req,
  input  logic [DATA_BITS-1:0] a,
  input  logic [DATA_BITS-1:0] b,
  output trm_pkg::alu_rsp_t    rsp,
  output logic [DATA_BITS-1:0] result
);
  import trm_pkg::*;

  localparam int W        = DATA_BITS + 2;
  localparam int CNT_BITS = $clog2(DATA_BITS + 1);

  alu_state_t           state, state_next;
  alu_op_t              op_r;
  logic [DATA_BITS-1:0] ra, rb, rq;
  logic [CNT_BITS-1:0]  cnt;
  logic                 neg_a, neg_b;
  logic                 done_r, eq_r, lt_r;
  logic [DATA_BITS-1:0] res_r;

  logic [W-1:0] ax, ay, sum;
  logic         sub;
  logic         last;

  // The one shared adder; the sequencer steers its operands.
  always_comb begin
    ax  = '0;
    ay  = '0;
    sub = 1'b0;
    case (state)
      A_SIMPLE: begin
        ax  = W'(signed'(ra));
        ay  = W'(signed'(rb));
        sub = (op_r != ALU_ADD);
      end
      A_MUL: begin
        ax = W'(ra);
        ay = W'(rb);
      end
      A_NEGA: begin
        ay  = W'(ra);
        sub = 1'b1;
      end
      A_NEGB: begin
        ay  = W'(rb);
        sub = 1'b1;
      end
      A_DIV: begin
        ax  = W'({ra, rq[DATA_BITS-1]});
        ay  = W'(rb);
        sub = 1'b1;
      end
      A_FIX: begin
        ay  = W'(rq);
        sub = 1'b1;
      end
      default: begin
        ax = '0;
      end
    endcase
    sum = ax + (ay ^ {W{sub}}) + W'(sub);
  end

  assign last = (cnt == CNT_BITS'(DATA_BITS - 1));

  always_comb begin
    state_next = state;
    case (state)
      A_IDLE: begin
        if (req.start) begin
          case (req.op)
            ALU_MUL: state_next = A_MUL;
            ALU_DIV: state_next = A_NEGA;
            default: state_next = A_SIMPLE;
          endcase
        end
      end
      A_SIMPLE: state_next = A_IDLE;
      A_MUL:    state_next = last ? A_IDLE : A_MUL;
      A_NEGA:   state_next = A_NEGB;
      A_NEGB:   state_next = A_DIV;
      A_DIV:    state_next = last ? A_FIX : A_DIV;
      A_FIX:    state_next = A_IDLE;
      default:  state_next = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      state  <= state_next;
      done_r <= (state == A_SIMPLE) || (state == A_FIX) || ((state == A_MUL) && last);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      A_IDLE: begin
        op_r  <= req.op;
        cnt   <= '0;
        neg_a <= a[DATA_BITS-1];
        neg_b <= b[DATA_BITS-1];
        if (req.op == ALU_MUL) begin
          ra <= '0;
          rb <= a;
          rq <= b;
        end else begin
          ra <= a;
          rb <= b;
        end
      end
      A_SIMPLE: begin
        res_r <= sum[DATA_BITS-1:0];
        eq_r  <= (sum == '0);
        lt_r  <= sum[W-1];
      end
      A_MUL: begin
        if (rq[0]) begin
          ra <= sum[DATA_BITS-1:0];
        end
        res_r <= rq[0] ? sum[DATA_BITS-1:0] : ra;
        rb    <= {rb[DATA_BITS-2:0], 1'b0};
        rq    <= {1'b0, rq[DATA_BITS-1:1]};
        cnt   <= cnt + 1'b1;
      end
      A_NEGA: begin
        rq <= neg_a ? sum[DATA_BITS-1:0] : ra;
        ra <= '0;
      end
      A_NEGB: begin
        if (neg_b) begin
          rb <= sum[DATA_BITS-1:0];
        end
        cnt <= '0;
      end
      A_DIV: begin
        // Restoring step: keep the difference when it does not borrow.
        if (!sum[W-1]) begin
          ra <= sum[DATA_BITS-1:0];
        end else begin
          ra <= {ra[DATA_BITS-2:0], rq[DATA_BITS-1]};
        end
        rq  <= {rq[DATA_BITS-2:0], ~sum[W-1]};
        cnt <= cnt + 1'b1;
      end
      A_FIX: begin
        res_r <= (neg_a != neg_b) ? sum[DATA_BITS-1:0] : rq;
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.eq   = eq_r;
  assign rsp.lt   = lt_r;
  assign result   = res_r;

endmodule

// ----- hw/rtl/tiny_register_machine_execute_core.sv -----
// Top level of the tiny register machine execute core: instruction decode,
// register file, sequencer and result register. Depends on trm_pkg, trm_alu.
//
// Usage: each transaction on the slave stream (s_tvalid, s_tready, s_tdata)
// carries one instruction: opcode, three one-hot register selectors and a
// 32-bit immediate. Each instruction yields exactly one transaction on the
// master stream (m_tvalid, m_tready, m_tdata) with the status, all four
// registers, both compare flags and the next program index after the step.
// The core works on one instruction at a time and s_tready is high only while
// it is idle. Halt, load, jump, no-ops, ignored items, bad selectors and bad
// jumps go from decode straight to the result state. Add, sub, cmp, multiply
// and divide read the second operand and wait for trm_alu, whose shared adder
// retires one multiplier bit or one quotient bit per cycle; a divide by zero
// is caught when the second operand is read. The core is ready again in the
// cycle after the result is loaded into the output register.
// A halt or error stops the machine; later instructions report "ignored" and
// change nothing until reset. Reset (rst, synchronous) clears the registers,
// flags, program index and stopped bit, and drops m_tvalid. If the receiver
// stalls, the result stays in the output register and a later result waits.

module tiny_register_machine_execute_core #(
  parameter int DATA_BITS  = trm_pkg::DATA_BITS_DEF,
  parameter int INDEX_BITS = trm_pkg::INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // operation [7:0], register_selects [23:8], immediate [55:24]
  input  logic [trm_pkg::S_DATA_BITS-1:0] s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status [2:0], first_register [34:3], second_register [66:35],
  // third_register [98:67], fourth_register [130:99], equal_flag [131],
  // less_flag [132], next_index [148:133], zero fill [151:149]
  output logic [trm_pkg::M_DATA_BITS-1:0] m_tdata
);
  import trm_pkg::*;

  // Registered copy of the instruction in flight.
  logic [OP_BITS-1:0]         op_r;
  logic [SEL_BITS-1:0]        sel_r;
  logic signed [IMM_BITS-1:0] imm_r;

  // Architectural state.
  logic [DATA_BITS-1:0]  rf [REG_COUNT];
  logic                  eq_mark, lt_mark;
  logic [INDEX_BITS-1:0] pc;
  logic                  stopped;
  logic [STATUS_BITS-1:0] status_r;
  logic [DATA_BITS-1:0]  opa_r;

  core_state_t state, state_next;

  // Control from the sequencer.
  logic                   rf_we;
  logic [1:0]             rf_waddr;
  logic [DATA_BITS-1:0]   rf_wdata;
  logic                   pc_we;
  logic [INDEX_BITS-1:0]  pc_next;
  logic                   stop_set;
  logic                   status_we;
  logic [STATUS_BITS-1:0] status_next;
  logic                   flags_we;
  logic                   opa_we;
  logic                   out_load;
  alu_req_t               alu_req;
  alu_rsp_t               alu_rsp;
  logic [DATA_BITS-1:0]   alu_result;

  sel_pick_t sa, sb, sd;
  logic [DATA_BITS-1:0]  rdata;
  logic [1:0]            raddr;
  logic [DATA_BITS-1:0]  load_val;
  logic [IMM_BITS-1:0]   raw;
  logic                  jump_bad;
  logic [INDEX_BITS-1:0] pc_inc;

  assign sa = sel_pick(sel_r[15:12]);
  assign sb = sel_pick(sel_r[11:8]);
  assign sd = sel_pick(sel_r[7:4]);

  // A single read port; the sequencer reads A while decoding and B after.
  assign raddr = (state == C_READB) ? sb.idx : sa.idx;
  assign rdata = rf[raddr];

  assign load_val = DATA_BITS'(imm_r);
  assign raw      = imm_r;
  assign jump_bad = raw[IMM_BITS-1] || ((raw >> INDEX_BITS) != '0);
  assign pc_inc   = pc + 1'b1;

  trm_alu #(
    .DATA_BITS(DATA_BITS)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (opa_r),
    .b      (rdata),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    rf_we       = 1'b0;
    rf_waddr    = sa.idx;
    rf_wdata    = load_val;
    pc_we       = 1'b0;
    pc_next     = pc_inc;
    stop_set    = 1'b0;
    status_we   = 1'b0;
    status_next = ST_OK;
    flags_we    = 1'b0;
    opa_we      = 1'b0;
    out_load    = 1'b0;
    alu_req     = '{start: 1'b0, op: ALU_ADD};

    case (state)
      C_IDLE: begin
        // No transaction is taken while reset is held.
        s_tready = !rst;
        if (s_tvalid) begin
          state_next = C_DECODE;
        end
      end

      C_DECODE: begin
        status_we  = 1'b1;
        state_next = C_RESULT;
        if (stopped) begin
          status_next = ST_IGNORED;
        end else if (op_r == OP_HALT) begin
          status_next = ST_HALT;
          stop_set    = 1'b1;
        end else if (op_r == OP_LOAD) begin
          if (!sa.ok) begin
            status_next = ST_BADREG;
            stop_set    = 1'b1;
          end else begin
            rf_we = 1'b1;
            pc_we = 1'b1;
          end
        end else if (op_r inside {[OP_ADD:OP_CMP]}) begin
          if (!(sa.ok && sb.ok && sd.ok)) begin
            status_next = ST_BADREG;
            stop_set    = 1'b1;
          end else begin
            status_we  = 1'b0;
            opa_we     = 1'b1;
            state_next = C_READB;
          end
        end else if (op_r == OP_JUMP) begin
          if (jump_bad) begin
            status_next = ST_BADJUMP;
            stop_set    = 1'b1;
          end else begin
            pc_we   = 1'b1;
            pc_next = INDEX_BITS'(raw);
          end
        end else begin
          // Unused opcodes only advance the program index.
          pc_we = 1'b1;
        end
      end

      C_READB: begin
        if ((op_r == OP_DIV) && (rdata == '0)) begin
          status_we   = 1'b1;
          status_next = ST_DIVZERO;
          stop_set    = 1'b1;
          state_next  = C_RESULT;
        end else begin
          alu_req.start = 1'b1;
          case (op_r)
            OP_ADD:  alu_req.op = ALU_ADD;
            OP_SUB:  alu_req.op = ALU_SUB;
            OP_MULT: alu_req.op = ALU_MUL;
            OP_DIV:  alu_req.op = ALU_DIV;
            default: alu_req.op = ALU_CMP;
          endcase
          state_next = C_WAIT;
        end
      end

      C_WAIT: begin
        rf_waddr = sd.idx;
        rf_wdata = alu_result;
        if (alu_rsp.done) begin
          status_we  = 1'b1;
          pc_we      = 1'b1;
          flags_we   = (op_r == OP_CMP);
          rf_we      = (op_r != OP_CMP);
          state_next = C_RESULT;
        end
      end

      C_RESULT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = C_IDLE;
        end
      end

      default: begin
        state_next = C_IDLE;
      end
    endcase
  end

  // Instruction capture and operand latch.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_r  <= s_tdata[7:0];
      sel_r <= s_tdata[23:8];
      imm_r <= s_tdata[55:24];
    end
    if (opa_we) begin
      opa_r <= rdata;
    end
    if (status_we) begin
      status_r <= status_next;
    end
  end

  // Machine state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        rf[i] <= '0;
      end
      eq_mark <= 1'b0;
      lt_mark <= 1'b0;
      pc      <= '0;
      stopped <= 1'b0;
    end else begin
      if (rf_we) begin
        rf[rf_waddr] <= rf_wdata;
      end
      if (flags_we) begin
        eq_mark <= alu_rsp.eq;
        lt_mark <= alu_rsp.lt;
      end
      if (pc_we) begin
        pc <= pc_next;
      end
      if (stop_set) begin
        stopped <= 1'b1;
      end
    end
  end

  // Output register; it holds its transaction while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {
        (M_DATA_BITS - M_USED_BITS)'(0),
        NEXT_OUT_BITS'(pc),
        lt_mark,
        eq_mark,
        REG_OUT_BITS'(rf[3]),
        REG_OUT_BITS'(rf[2]),
        REG_OUT_BITS'(rf[1]),
        REG_OUT_BITS'(rf[0]),
        status_r
      };
    end
  end

endmodule

// ----- hw/rtl/trm_checker.sv -----
// Port-level checker for the tiny register machine execute core, bound to
// the top level. Depends on trm_pkg and tiny_register_machine_execute_core.

module trm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [trm_pkg::M_DATA_BITS-1:0] m_tdata
);
  import trm_pkg::*;

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // One instruction at a time: after a transaction the core is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("core ready right after accepting an instruction");

  // A stalled result holds.
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // Only defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] == ST_OK || m_tdata[2:0] == ST_HALT ||
                  m_tdata[2:0] == ST_BADREG || m_tdata[2:0] == ST_DIVZERO ||
                  m_tdata[2:0] == ST_BADJUMP || m_tdata[2:0] == ST_IGNORED))
    else $error("undefined status code");

  // Fill bits above the last field stay zero.
  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[M_DATA_BITS-1:M_USED_BITS] == '0))
    else $error("nonzero fill bits");

endmodule

bind tiny_register_machine_execute_core trm_checker u_trm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
